/* rtl/sfd_pkg.sv */
// Shared constants and types for the SBUS frame decoder.
// No dependencies.
`default_nettype none

package sfd_pkg;

    // frame layout
    localparam int FRAME_BYTES  = 25;
    localparam int FLAGS_POS    = 23;
    localparam int FOOTER_POS   = 24;
    localparam int FIRST_DATA   = 1;
    localparam int LAST_DATA    = 22;
    localparam int NUM_CHANNELS = 16;
    localparam int CHAN_BITS    = 11;
    localparam logic [10:0] CHAN_MASK = 11'h7FF;

    // widths
    localparam int IDX_W   = 5;   // byte position in a frame
    localparam int ACC_W   = 24;  // channel bit buffer
    localparam int NBITS_W = 5;   // bits held in the buffer

    // register reset values
    localparam logic [7:0] HEADER_RESET = 8'h0F;
    localparam logic [7:0] FOOTER_RESET = 8'h00;

    // configuration register indexes
    localparam logic [7:0] REG_HEADER = 8'd0;
    localparam logic [7:0] REG_FOOTER = 8'd1;

    // frame check result
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEN  = 2'd1,
        ST_BAD_HEAD = 2'd2,
        ST_BAD_FOOT = 2'd3
    } status_t;

endpackage

`default_nettype wire

/* rtl/sbus_frame_decoder_core.sv */
// SBUS frame decoder: byte stream in, one word per channel out.
// Depends on sfd_pkg.
//
// Throughput: one byte per cycle in while the write bank is free. A good frame
// holds its bank while its 16 words drain, paced by the byte fetch, which waits
// until the 24-bit bit buffer surely has room.
// Two frame banks: a new frame fills one bank while the other drains; input
// stalls only when both banks hold frames, so back-to-back good 25-byte frames
// make the input stall. Reset clears control state and loads header 0x0F,
// footer 0x00; the frame store itself is not cleared.
`default_nettype none

module sbus_frame_decoder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tlast,   // frame_end
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [3:0] channel_index, [14:4] channel_value,
                                             // [15] aux_ch17, [16] aux_ch18,
                                             // [17] lost_frame, [18] fail_safe, rest 0
    output logic [1:0]       m_axis_tuser,   // [1:0] status
    output logic             m_axis_tlast,   // last
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import sfd_pkg::*;

    // frame store: two banks of 32 entries, 25 used each
    logic [7:0] mem [0:63];

    // configuration
    logic [7:0] header_reg;
    logic [7:0] footer_reg;

    // write side
    logic             wr_bank_reg;
    logic [IDX_W-1:0] count_reg;
    logic [7:0]       head_byte_reg;
    logic [7:0]       foot_byte_reg;

    // per-bank frame jobs
    logic [1:0]       busy_reg;
    status_t          status_reg [0:1];
    logic [3:0]       flags_reg  [0:1];

    // drain side
    logic               rd_bank_reg;
    logic [IDX_W-1:0]   rd_ptr_reg;
    logic               rd_vld_reg;
    logic [7:0]         rd_data_reg;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [NBITS_W-1:0] nbits_reg, nbits_next;
    logic [3:0]         ch_cnt_reg;

    // output register
    logic        out_valid_reg;
    logic [3:0]  out_index_reg;
    logic [10:0] out_value_reg;
    logic [3:0]  out_flags_reg;
    status_t     out_status_reg;
    logic        out_last_reg;

    logic    in_acc;
    logic    frame_done;
    logic    len_ok;
    logic    head_ok;
    logic    foot_ok;
    logic [7:0] byte0;
    logic [7:0] byte24;
    status_t chk_status;
    logic    job_active;
    logic    job_good;
    logic    out_free;
    logic    emit_ch;
    logic    emit_err;
    logic    job_done;
    logic    rd_issue;
    logic [ACC_W-1:0]   acc_base;
    logic [NBITS_W-1:0] nb_base;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !busy_reg[wr_bank_reg];
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign frame_done    = in_acc && s_axis_tlast;

    // frame checks, using the current byte where it lands at a checked position
    assign byte0   = (count_reg == '0) ? s_axis_tdata : head_byte_reg;
    assign byte24  = (count_reg == IDX_W'(FOOTER_POS)) ? s_axis_tdata : foot_byte_reg;
    assign len_ok  = (count_reg >= IDX_W'(FRAME_BYTES - 1));
    assign head_ok = (byte0 == header_reg);
    assign foot_ok = (byte24 == footer_reg);

    always_comb
    begin
        if (!len_ok)
            chk_status = ST_BAD_LEN;
        else if (!head_ok)
            chk_status = ST_BAD_HEAD;
        else if (!foot_ok)
            chk_status = ST_BAD_FOOT;
        else
            chk_status = ST_OK;
    end

    // drain control
    assign job_active = busy_reg[rd_bank_reg];
    assign job_good   = job_active && (status_reg[rd_bank_reg] == ST_OK);
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign emit_ch    = job_good && (nbits_reg >= NBITS_W'(CHAN_BITS)) && out_free;
    assign emit_err   = job_active && (status_reg[rd_bank_reg] != ST_OK) && out_free;
    assign job_done   = emit_err || (emit_ch && (ch_cnt_reg == 4'(NUM_CHANNELS - 1)));
    assign rd_issue   = job_good && (rd_ptr_reg <= IDX_W'(LAST_DATA)) &&
                        (rd_vld_reg ? (nbits_reg <= NBITS_W'(8)) :
                                      (nbits_reg <= NBITS_W'(16)));

    // bit buffer: drop an emitted channel, append an arriving byte
    always_comb
    begin
        acc_base = emit_ch ? (acc_reg >> CHAN_BITS) : acc_reg;
        nb_base  = emit_ch ? (nbits_reg - NBITS_W'(CHAN_BITS)) : nbits_reg;
        if (rd_vld_reg)
        begin
            acc_next   = acc_base | (ACC_W'(rd_data_reg) << nb_base);
            nbits_next = nb_base + NBITS_W'(8);
        end
        else
        begin
            acc_next   = acc_base;
            nbits_next = nb_base;
        end
    end

    // frame store write and read port
    always_ff @(posedge clk)
    begin
        if (in_acc && (count_reg < IDX_W'(FRAME_BYTES)))
            mem[{wr_bank_reg, count_reg}] <= s_axis_tdata;
        rd_data_reg <= mem[{rd_bank_reg, rd_ptr_reg}];
    end

    // frame payload captured while filling; flags and status are kept per bank
    always_ff @(posedge clk)
    begin
        if (in_acc && (count_reg == IDX_W'(0)))
            head_byte_reg <= s_axis_tdata;
        if (in_acc && (count_reg == IDX_W'(FOOTER_POS)))
            foot_byte_reg <= s_axis_tdata;
        if (in_acc && (count_reg == IDX_W'(FLAGS_POS)))
            flags_reg[wr_bank_reg] <= s_axis_tdata[3:0];
        if (frame_done)
            status_reg[wr_bank_reg] <= chk_status;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
            footer_reg <= FOOTER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HEADER: header_reg <= cfg_data;
                REG_FOOTER: footer_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // write side and bank bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_bank_reg <= 1'b0;
            count_reg   <= '0;
            busy_reg    <= '0;
        end
        else
        begin
            if (frame_done)
            begin
                count_reg   <= '0;
                wr_bank_reg <= !wr_bank_reg;
            end
            else if (in_acc && (count_reg < IDX_W'(FRAME_BYTES)))
                count_reg <= count_reg + IDX_W'(1);

            // the two banks never coincide here: a busy write bank blocks input
            if (frame_done)
                busy_reg[wr_bank_reg] <= 1'b1;
            if (job_done)
                busy_reg[rd_bank_reg] <= 1'b0;
        end
    end

    // drain engine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_bank_reg <= 1'b0;
            rd_ptr_reg  <= IDX_W'(FIRST_DATA);
            rd_vld_reg  <= 1'b0;
            acc_reg     <= '0;
            nbits_reg   <= '0;
            ch_cnt_reg  <= '0;
        end
        else
        begin
            rd_vld_reg <= rd_issue;
            if (job_done)
            begin
                rd_bank_reg <= !rd_bank_reg;
                rd_ptr_reg  <= IDX_W'(FIRST_DATA);
                acc_reg     <= '0;
                nbits_reg   <= '0;
                ch_cnt_reg  <= '0;
            end
            else
            begin
                if (rd_issue)
                    rd_ptr_reg <= rd_ptr_reg + IDX_W'(1);
                acc_reg   <= acc_next;
                nbits_reg <= nbits_next;
                if (emit_ch)
                    ch_cnt_reg <= ch_cnt_reg + 4'd1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_ch || emit_err)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_ch)
        begin
            out_index_reg  <= ch_cnt_reg;
            out_value_reg  <= acc_reg[CHAN_BITS-1:0] & CHAN_MASK;
            out_flags_reg  <= flags_reg[rd_bank_reg];
            out_status_reg <= ST_OK;
            out_last_reg   <= (ch_cnt_reg == 4'(NUM_CHANNELS - 1));
        end
        else if (emit_err)
        begin
            out_index_reg  <= '0;
            out_value_reg  <= '0;
            out_flags_reg  <= '0;
            out_status_reg <= status_reg[rd_bank_reg];
            out_last_reg   <= 1'b1;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_flags_reg, out_value_reg, out_index_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for sbus_frame_decoder_core: byte stream in, channel words out.
// Depends on sfd_pkg and the core. A behavioral decoder model predicts the channel words of untyped frames.
`default_nettype none

module testbench;
    import sfd_pkg::*;

    // register indexes the core does not decode; writes there must do nothing
    localparam logic [7:0] REG_UNUSED_LO = 8'd2;
    localparam logic [7:0] REG_UNUSED_HI = 8'hFF;
    // quiet time after the last word: output latency plus a full drain
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_BYTES  = 20;
    localparam int MAX_PRINTS   = 50;

    // one expected channel word
    typedef struct packed {
        logic [3:0]  idx;
        logic [10:0] val;
        logic [3:0]  flags;   // ch17, ch18, lost, failsafe from bit 0 up
        status_t     st;
        logic        last;
    } chan_word_t;

    // one frame to send; typed rows carry their own expected outcome
    typedef struct packed {
        int          n;
        logic [7:0]  b0;
        logic [7:0]  fill;
        logic [7:0]  b23;
        logic [7:0]  b24;
        bit          rnd;     // random payload bytes
        bit          noise;   // every byte random
        bit          typed;
        status_t     tst;
        logic [10:0] tval;
    } frame_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 8'h00;
    logic [7:0]  cfg_data = 8'h00;

    // decoder model state
    logic [7:0]  frame_img [FRAME_BYTES];
    logic [4:0]  fill_cnt;
    logic [7:0]  hdr_reg;
    logic [7:0]  ftr_reg;
    chan_word_t  calc_words [NUM_CHANNELS];
    chan_word_t  pending_words [$];

    int  err_count = 0;
    bit  src_busy = 1'b0;
    bit  sink_busy = 1'b0;

    sbus_frame_decoder_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // one line per mismatch, printing capped
    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (err_count < MAX_PRINTS)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        err_count++;
    endtask

    // idle cycles before the next word; busy stretches give back-to-back traffic
    function automatic int draw_gap(ref bit busy);
        if ($urandom_range(0, 15) == 0)
            busy = !busy;
        return busy ? 0 : $urandom_range(0, 15);
    endfunction

    // model: store one byte, decode the frame on its end; returns number of words
    function automatic int decode_byte(input logic [7:0] b, input logic e);
        status_t     st;
        int          bitpos;
        int          bp;
        logic [23:0] w24;
        logic [23:0] sh24;
        if (fill_cnt < FRAME_BYTES) begin
            frame_img[fill_cnt] = b;
            fill_cnt = fill_cnt + 5'd1;
        end
        if (!e)
            return 0;
        if (fill_cnt != FRAME_BYTES)
            st = ST_BAD_LEN;
        else if (frame_img[0] != hdr_reg)
            st = ST_BAD_HEAD;
        else if (frame_img[FOOTER_POS] != ftr_reg)
            st = ST_BAD_FOOT;
        else
            st = ST_OK;
        fill_cnt = 5'd0;
        if (st != ST_OK) begin
            calc_words[0] = '{idx: 4'd0, val: 11'd0, flags: 4'd0, st: st, last: 1'b1};
            return 1;
        end
        // channels are packed little-endian, 11 bits each, from byte 1 on
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            bitpos = CHAN_BITS * k;
            bp     = 1 + bitpos / 8;
            w24    = {frame_img[bp + 2], frame_img[bp + 1], frame_img[bp]};
            sh24   = w24 >> (bitpos % 8);
            calc_words[k] = '{idx: k[3:0], val: sh24[10:0],
                              flags: frame_img[FLAGS_POS][3:0], st: ST_OK,
                              last: (k == NUM_CHANNELS - 1)};
        end
        return NUM_CHANNELS;
    endfunction

    // drive one byte, then log what the frame end is expected to produce
    task automatic push_byte(input logic [7:0] b, input logic e, input frame_row_t r);
        int gap;
        int nw;
        gap = draw_gap(src_busy);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= e;
        do @(posedge clk); while (!s_axis_tready);
        nw = decode_byte(b, e);
        if (r.typed && e) begin
            if (r.tst == ST_OK) begin
                for (int k = 0; k < NUM_CHANNELS; k++)
                    pending_words.push_back('{idx: k[3:0], val: r.tval, flags: r.b23[3:0],
                                              st: ST_OK, last: (k == NUM_CHANNELS - 1)});
            end else begin
                pending_words.push_back('{idx: 4'd0, val: 11'd0, flags: 4'd0,
                                          st: r.tst, last: 1'b1});
            end
        end else begin
            for (int k = 0; k < nw; k++)
                pending_words.push_back(calc_words[k]);
        end
    endtask

    // send a whole reception; the last byte carries tlast
    task automatic send_frame(input frame_row_t r, output int sent);
        logic [7:0] b;
        for (int p = 0; p < r.n; p++) begin
            if (r.noise)
                b = 8'($urandom);
            else if (p == 0)
                b = r.b0;
            else if (p == FLAGS_POS)
                b = r.b23;
            else if (p == FOOTER_POS)
                b = r.b24;
            else if (r.rnd)
                b = 8'($urandom);
            else
                b = r.fill;
            push_byte(b, (p == r.n - 1), r);
        end
        sent = r.n;
    endtask

    // register write, mirrored into the model on the handshake
    task automatic cfg_write(input logic [7:0] idx, input logic [7:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_HEADER)
            hdr_reg = data;
        else if (idx == REG_FOOTER)
            ftr_reg = data;
    endtask

    // stop sending and let every expected word come out
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic frame_row_t mk_row(input int n, input logic [7:0] b0,
                                          input logic [7:0] fill, input logic [7:0] b23,
                                          input logic [7:0] b24, input bit rnd,
                                          input bit typed, input status_t tst,
                                          input logic [10:0] tval);
        return '{n: n, b0: b0, fill: fill, b23: b23, b24: b24, rnd: rnd, noise: 1'b0,
                 typed: typed, tst: tst, tval: tval};
    endfunction

    // random frame: mostly well formed, some broken, some pure noise
    function automatic frame_row_t rand_row();
        frame_row_t r;
        int kind;
        r = mk_row(FRAME_BYTES, hdr_reg, 8'h00, 8'($urandom), ftr_reg, 1'b1, 1'b0, ST_OK,
                   11'd0);
        kind = $urandom_range(0, 9);
        case (kind)
            5: r.n = $urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 6);
            6: r.n = $urandom_range(1, FRAME_BYTES - 1);
            7: r.b0 = hdr_reg ^ 8'($urandom_range(1, 255));
            8: r.b24 = ftr_reg ^ 8'($urandom_range(1, 255));
            9:
            begin
                r.noise = 1'b1;
                r.n = $urandom_range(1, FRAME_BYTES + 5);
            end
            default: ;
        endcase
        return r;
    endfunction

    // result side: random tready stalls, compare each word with the oldest expectation
    initial begin : result_check
        chan_word_t w;
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_words.size() == 0) begin
                    report("word with none expected", {8'h00, m_axis_tdata}, 32'h0);
                end else begin
                    w = pending_words.pop_front();
                    if (m_axis_tdata[3:0] !== w.idx)
                        report("channel_index", 32'(m_axis_tdata[3:0]), 32'(w.idx));
                    if (m_axis_tdata[14:4] !== w.val)
                        report("channel_value", 32'(m_axis_tdata[14:4]), 32'(w.val));
                    if (m_axis_tdata[15] !== w.flags[0])
                        report("aux_ch17", 32'(m_axis_tdata[15]), 32'(w.flags[0]));
                    if (m_axis_tdata[16] !== w.flags[1])
                        report("aux_ch18", 32'(m_axis_tdata[16]), 32'(w.flags[1]));
                    if (m_axis_tdata[17] !== w.flags[2])
                        report("lost_frame", 32'(m_axis_tdata[17]), 32'(w.flags[2]));
                    if (m_axis_tdata[18] !== w.flags[3])
                        report("fail_safe", 32'(m_axis_tdata[18]), 32'(w.flags[3]));
                    if (m_axis_tuser !== w.st)
                        report("status", 32'(m_axis_tuser), 32'(w.st));
                    if (m_axis_tlast !== w.last)
                        report("last", 32'(m_axis_tlast), 32'(w.last));
                end
                stall_left = draw_gap(sink_busy);
                if (stall_left > 0)
                    m_axis_tready <= 1'b0;
            end else if (!m_axis_tready) begin
                if (stall_left > 0)
                    stall_left--;
                if (stall_left == 0)
                    m_axis_tready <= 1'b1;
            end
        end
    end

    // main sequence
    initial begin : stimulus
        frame_row_t rows [6];
        frame_row_t r;
        logic [7:0] hdr_new;
        logic [7:0] ftr_new;
        int sent;
        int total;

        fill_cnt = 5'd0;
        hdr_reg  = HEADER_RESET;
        ftr_reg  = FOOTER_RESET;
        for (int i = 0; i < FRAME_BYTES; i++)
            frame_img[i] = 8'h00;

        // directed frames under the reset register values
        rows[0] = mk_row(1, HEADER_RESET, 8'h00, 8'h00, FOOTER_RESET, 0, 1, ST_BAD_LEN, 0);
        // length is checked before header, header before footer
        rows[1] = mk_row(2, 8'hF0, 8'h33, 8'h00, 8'hFF, 0, 1, ST_BAD_LEN, 0);
        rows[2] = mk_row(FRAME_BYTES, HEADER_RESET, 8'hFF, 8'h0F, FOOTER_RESET, 0, 1,
                         ST_OK, 11'h7FF);
        rows[3] = mk_row(FRAME_BYTES, 8'hF0, 8'h33, 8'h00, 8'hFF, 0, 1, ST_BAD_HEAD, 0);
        rows[4] = mk_row(FRAME_BYTES, HEADER_RESET, 8'h33, 8'h00, 8'h01, 0, 1,
                         ST_BAD_FOOT, 0);
        // bytes past the 25th are dropped
        rows[5] = mk_row(FRAME_BYTES + 2, HEADER_RESET, 8'h00, 8'hA5, FOOTER_RESET, 1, 0,
                         ST_OK, 0);

        hdr_new = 8'($urandom);
        ftr_new = 8'($urandom);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_frame(rows[i], sent);

        // random frames under a new register setting
        wait_idle();
        cfg_write(REG_HEADER, hdr_new);
        cfg_write(REG_FOOTER, ftr_new);
        cfg_write(REG_UNUSED_LO, 8'h00);
        cfg_write(REG_UNUSED_HI, 8'hFF);
        total = 0;
        while (total < PHASE_BYTES) begin
            r = rand_row();
            send_frame(r, sent);
            total += sent;
        end

        wait_idle();
        if (err_count == 0 && pending_words.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #1000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
rtl/sfd_pkg.sv
rtl/sbus_frame_decoder_core.sv
bench/testbench.sv
